FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/tcd_pkg.sv
// Shared types, constants and byte helpers of the terminal cell diff encoder.
`timescale 1ns / 1ps
package tcd_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;
    localparam int DEC_W        = 10;
    localparam int CELL_W       = 16;

    // Request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_CELL  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // Stream bytes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LB    = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Four-byte fixed sequences
    localparam logic SEQ_CLS = 1'b0;
    localparam logic SEQ_RST = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DEC_W-1:0] value;
    } dec_req_t;

    typedef struct packed {
        logic       done;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } dec_rsp_t;

    // Byte of clear-screen or attribute-reset sequence
    function automatic logic [7:0] seq4_byte(input logic sel, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CH_ESC;
            2'd1:    b = CH_LB;
            2'd2:    b = (sel == SEQ_RST) ? CH_ZERO : CH_TWO;
            default: b = (sel == SEQ_RST) ? CH_M : CH_J;
        endcase
        return b;
    endfunction

    // SGR code digit for attribute bit
    function automatic logic [7:0] attr_code(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h31;
            2'd1:    b = 8'h32;
            2'd2:    b = 8'h34;
            default: b = 8'h37;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CH_ZERO + {4'b0000, d};
    endfunction

endpackage

FILE: design/tcd_dec_unit.sv
// Iterative decimal splitter: one shared compare-subtract per cycle.
`timescale 1ns / 1ps
module tcd_dec_unit import tcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dec_req_t req,
    output dec_rsp_t rsp
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUND = 2'd1;
    localparam logic [1:0] PH_TENS = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [DEC_W-1:0] rem_reg, rem_next;
    logic [3:0]       hund_reg, hund_next;
    logic [3:0]       tens_reg, tens_next;
    logic             done_reg, done_next;
    logic [DEC_W-1:0] step;
    logic [DEC_W-1:0] diff;
    logic             ge;

    // Shared subtractor
    assign step = (phase_reg == PH_HUND) ? DEC_W'(100) : DEC_W'(10);
    assign ge   = (rem_reg >= step);
    assign diff = rem_reg - step;

    // Step through hundreds, then tens
    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        hund_next  = hund_reg;
        tens_next  = tens_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_HUND:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    hund_next = hund_reg + 4'd1;
                end
                else
                begin
                    phase_next = PH_TENS;
                end
            end
            PH_TENS:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    tens_next = tens_reg + 4'd1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (req.start)
        begin
            rem_next   = req.value;
            hund_next  = 4'd0;
            tens_next  = 4'd0;
            phase_next = PH_HUND;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= '0;
            hund_reg  <= '0;
            tens_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            hund_reg  <= hund_next;
            tens_reg  <= tens_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hund = hund_reg;
    assign rsp.tens = tens_reg;
    assign rsp.ones = rem_reg[3:0];

endmodule

FILE: design/terminal_cell_diff_encoder_unit.sv
// Top level of the terminal cell diff encoder: sequencer, shown-cell memory, byte output.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | req_type frame_width frame_height char_code
//          |           |                       | cell_attr cell_color
//  out     | output    | out_valid / out_ready | out_byte last_byte
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (active)
//
// An unchanged cell is only compared; a skipped item or a same-size frame start sends nothing.
// A changed cell takes a compare state, one state per byte, one per clear attribute bit, and
// per number sent a wait on the decimal unit plus one state per dropped leading zero.
// A size change sends 4 bytes, then rewrites the width*height cells, each read then written.
// Session open clears the grid, one entry per cycle (MAX_COLS*MAX_ROWS), with in_ready low.
// Output stalls hold the sequencer; a pending last byte waits as the next transaction is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module terminal_cell_diff_encoder_unit import tcd_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] frame_width,
    input  logic [6:0] frame_height,
    input  logic [7:0] char_code,
    input  logic [3:0] cell_attr,
    input  logic [3:0] cell_color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int AREA_W = ADDR_W + 1;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_WIPE     = 5'd1;
    localparam logic [4:0] ST_SEQ4     = 5'd2;
    localparam logic [4:0] ST_SWP_RD   = 5'd3;
    localparam logic [4:0] ST_SWP_WR   = 5'd4;
    localparam logic [4:0] ST_CMP      = 5'd5;
    localparam logic [4:0] ST_CUR_ESC  = 5'd6;
    localparam logic [4:0] ST_CUR_LB   = 5'd7;
    localparam logic [4:0] ST_CUR_SEMI = 5'd8;
    localparam logic [4:0] ST_CUR_H    = 5'd9;
    localparam logic [4:0] ST_SGR_ESC  = 5'd10;
    localparam logic [4:0] ST_SGR_LB   = 5'd11;
    localparam logic [4:0] ST_SGR_0    = 5'd12;
    localparam logic [4:0] ST_SGR_ATTR = 5'd13;
    localparam logic [4:0] ST_SGR_CLR  = 5'd14;
    localparam logic [4:0] ST_SGR_M    = 5'd15;
    localparam logic [4:0] ST_CHAR     = 5'd16;
    localparam logic [4:0] ST_DEC_WAIT = 5'd17;
    localparam logic [4:0] ST_DEC_OUT  = 5'd18;

    // Control state
    logic [4:0]        state_reg, state_next;
    logic [4:0]        ret_reg, ret_next;
    logic              active_reg, active_next;
    logic [COL_W-1:0]  shown_w_reg, shown_w_next;
    logic [ROW_W-1:0]  shown_h_reg, shown_h_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [COL_W-1:0]  scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]  scan_row_reg, scan_row_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic              cur_known_reg, cur_known_next;
    logic [3:0]        st_attr_reg, st_attr_next;
    logic [3:0]        st_color_reg, st_color_next;
    logic              st_known_reg, st_known_next;
    logic              sgr_pend_reg, sgr_pend_next;
    logic              seq_sel_reg, seq_sel_next;
    logic [1:0]        idx_reg, idx_next;
    logic              aphase_reg, aphase_next;
    logic [AREA_W-1:0] sweep_reg, sweep_next;
    logic [ADDR_W-1:0] wipe_reg, wipe_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [7:0]        ch_reg;
    logic [3:0]        attr_reg;
    logic [3:0]        color_reg;
    logic [7:0]        out_byte_reg;
    logic              last_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic [CELL_W-1:0] mem [DEPTH];

    // Datapath
    logic              accept;
    logic              out_free;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [COL_W-1:0]  w_sat;
    logic [ROW_W-1:0]  h_sat;
    logic [COL_W+ROW_W-1:0] area_prod;
    logic [CELL_W-1:0] now_cell;
    logic              adv;
    logic [7:0]        print_ch;
    dec_req_t          dec_req;
    dec_rsp_t          dec_rsp;

    tcd_dec_unit u_dec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dec_req),
        .rsp   (dec_rsp)
    );

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Saturate frame size and form its cell count
    always_comb
    begin
        if ({24'd0, frame_width} > MAX_COLS)
            w_sat = COL_W'(MAX_COLS);
        else
            w_sat = COL_W'(frame_width);
        if ({25'd0, frame_height} > MAX_ROWS)
            h_sat = ROW_W'(MAX_ROWS);
        else
            h_sat = ROW_W'(frame_height);
    end
    assign area_prod = {{ROW_W{1'b0}}, w_sat} * {{COL_W{1'b0}}, h_sat};

    assign now_cell = {color_reg, attr_reg, ch_reg};
    assign print_ch = (ch_reg >= CH_SPACE && ch_reg <= CH_TILDE) ? ch_reg : CH_SPACE;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        active_next    = active_reg;
        shown_w_next   = shown_w_reg;
        shown_h_next   = shown_h_reg;
        area_next      = area_reg;
        scan_col_next  = scan_col_reg;
        scan_row_next  = scan_row_reg;
        scan_addr_next = scan_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cur_known_next = cur_known_reg;
        st_attr_next   = st_attr_reg;
        st_color_next  = st_color_reg;
        st_known_next  = st_known_reg;
        sgr_pend_next  = sgr_pend_reg;
        seq_sel_next   = seq_sel_reg;
        idx_next       = idx_reg;
        aphase_next    = aphase_reg;
        sweep_next     = sweep_reg;
        wipe_next      = wipe_reg;
        emit           = 1'b0;
        emit_byte      = CH_SPACE;
        emit_last      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = scan_addr_reg;
        wr_data        = now_cell;
        rd_addr        = scan_addr_reg;
        adv            = 1'b0;
        dec_req.start  = 1'b0;
        dec_req.value  = DEC_W'(scan_row_reg) + DEC_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && active_reg)
                begin
                    case (req_type)
                        REQ_START:
                        begin
                            scan_col_next  = '0;
                            scan_row_next  = '0;
                            scan_addr_next = '0;
                            cur_known_next = 1'b0;
                            st_known_next  = 1'b0;
                            if (w_sat != shown_w_reg || h_sat != shown_h_reg)
                            begin
                                shown_w_next = w_sat;
                                shown_h_next = h_sat;
                                area_next    = AREA_W'(area_prod);
                                seq_sel_next = SEQ_CLS;
                                idx_next     = 2'd0;
                                state_next   = ST_SEQ4;
                            end
                        end
                        REQ_CELL:
                        begin
                            if (shown_w_reg != '0 && scan_row_reg < shown_h_reg)
                                state_next = ST_CMP;
                        end
                        REQ_END:
                        begin
                            scan_col_next = '0;
                            scan_row_next = shown_h_reg;
                            seq_sel_next  = SEQ_RST;
                            idx_next      = 2'd0;
                            state_next    = ST_SEQ4;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WIPE:
            begin
                wr_en     = 1'b1;
                wr_addr   = wipe_reg;
                wr_data   = '0;
                wipe_next = wipe_reg + ADDR_W'(1);
                if (wipe_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_SEQ4:
            begin
                emit      = 1'b1;
                emit_byte = seq4_byte(seq_sel_reg, idx_reg);
                emit_last = (idx_reg == 2'd3);
                if (out_free)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        sweep_next = '0;
                        if (seq_sel_reg == SEQ_CLS && area_reg != '0)
                            state_next = ST_SWP_RD;
                        else
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_SWP_RD:
            begin
                rd_addr    = sweep_reg[ADDR_W-1:0];
                state_next = ST_SWP_WR;
            end
            ST_SWP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg[ADDR_W-1:0];
                wr_data    = rd_data_reg & 16'hFF00;
                sweep_next = sweep_reg + AREA_W'(1);
                if (sweep_reg + AREA_W'(1) == area_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SWP_RD;
            end
            ST_CMP:
            begin
                if (now_cell == rd_data_reg)
                begin
                    adv        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sgr_pend_next = !(st_known_reg && attr_reg == st_attr_reg &&
                                      color_reg == st_color_reg);
                    st_attr_next  = attr_reg;
                    st_color_next = color_reg;
                    st_known_next = 1'b1;
                    if (!(cur_known_reg && cur_row_reg == scan_row_reg &&
                          cur_col_reg == scan_col_reg))
                    begin
                        cur_row_next   = scan_row_reg;
                        cur_col_next   = scan_col_reg;
                        cur_known_next = 1'b1;
                        state_next     = ST_CUR_ESC;
                    end
                    else if (!(st_known_reg && attr_reg == st_attr_reg &&
                               color_reg == st_color_reg))
                    begin
                        state_next = ST_SGR_ESC;
                    end
                    else
                    begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CUR_ESC:
            begin
                emit      = 1'b1;
                emit_byte = CH_ESC;
                if (out_free)
                    state_next = ST_CUR_LB;
            end
            ST_CUR_LB:
            begin
                emit          = 1'b1;
                emit_byte     = CH_LB;
                dec_req.value = DEC_W'(scan_row_reg) + DEC_W'(1);
                if (out_free)
                begin
                    dec_req.start = 1'b1;
                    ret_next      = ST_CUR_SEMI;
                    state_next    = ST_DEC_WAIT;
                end
            end
            ST_CUR_SEMI:
            begin
                emit          = 1'b1;
                emit_byte     = CH_SEMI;
                dec_req.value = DEC_W'(scan_col_reg) + DEC_W'(1);
                if (out_free)
                begin
                    dec_req.start = 1'b1;
                    ret_next      = ST_CUR_H;
                    state_next    = ST_DEC_WAIT;
                end
            end
            ST_CUR_H:
            begin
                emit      = 1'b1;
                emit_byte = CH_H;
                if (out_free)
                    state_next = sgr_pend_reg ? ST_SGR_ESC : ST_CHAR;
            end
            ST_SGR_ESC:
            begin
                emit      = 1'b1;
                emit_byte = CH_ESC;
                if (out_free)
                    state_next = ST_SGR_LB;
            end
            ST_SGR_LB:
            begin
                emit      = 1'b1;
                emit_byte = CH_LB;
                if (out_free)
                    state_next = ST_SGR_0;
            end
            ST_SGR_0:
            begin
                emit      = 1'b1;
                emit_byte = CH_ZERO;
                if (out_free)
                begin
                    idx_next    = 2'd0;
                    aphase_next = 1'b0;
                    state_next  = ST_SGR_ATTR;
                end
            end
            ST_SGR_ATTR:
            begin
                // Send ';' and the code for each set attribute bit
                if (attr_reg[idx_reg])
                begin
                    emit      = 1'b1;
                    emit_byte = aphase_reg ? attr_code(idx_reg) : CH_SEMI;
                    if (out_free)
                    begin
                        aphase_next = !aphase_reg;
                        if (aphase_reg)
                        begin
                            idx_next = idx_reg + 2'd1;
                            if (idx_reg == 2'd3)
                                state_next = ST_SGR_CLR;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = ST_SGR_CLR;
                end
            end
            ST_SGR_CLR:
            begin
                dec_req.value = DEC_W'(color_reg) + DEC_W'(29);
                if (color_reg != 4'd0)
                begin
                    emit      = 1'b1;
                    emit_byte = CH_SEMI;
                    if (out_free)
                    begin
                        dec_req.start = 1'b1;
                        ret_next      = ST_SGR_M;
                        state_next    = ST_DEC_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_SGR_M;
                end
            end
            ST_SGR_M:
            begin
                emit      = 1'b1;
                emit_byte = CH_M;
                if (out_free)
                    state_next = ST_CHAR;
            end
            ST_CHAR:
            begin
                emit      = 1'b1;
                emit_byte = print_ch;
                emit_last = 1'b1;
                if (out_free)
                begin
                    wr_en        = 1'b1;
                    cur_col_next = cur_col_reg + COL_W'(1);
                    adv          = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DEC_WAIT:
            begin
                if (dec_rsp.done)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_DEC_OUT;
                end
            end
            ST_DEC_OUT:
            begin
                // Send digits without leading zeros
                case (idx_reg)
                    2'd0:
                    begin
                        emit      = (dec_rsp.hund != 4'd0);
                        emit_byte = digit_char(dec_rsp.hund);
                        if (out_free || !emit)
                            idx_next = 2'd1;
                    end
                    2'd1:
                    begin
                        emit      = (dec_rsp.hund != 4'd0) || (dec_rsp.tens != 4'd0);
                        emit_byte = digit_char(dec_rsp.tens);
                        if (out_free || !emit)
                            idx_next = 2'd2;
                    end
                    default:
                    begin
                        emit      = 1'b1;
                        emit_byte = digit_char(dec_rsp.ones);
                        if (out_free)
                            state_next = ret_reg;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the raster position
        if (adv)
        begin
            scan_addr_next = scan_addr_reg + ADDR_W'(1);
            if (scan_col_reg + COL_W'(1) >= shown_w_reg)
            begin
                scan_col_next = '0;
                scan_row_next = scan_row_reg + ROW_W'(1);
            end
            else
            begin
                scan_col_next = scan_col_reg + COL_W'(1);
            end
        end

        // Session open clears the shown grid
        if (cfg_valid && cfg_ready)
        begin
            active_next = cfg_data;
            if (cfg_data && !active_reg)
            begin
                shown_w_next   = '0;
                shown_h_next   = '0;
                scan_col_next  = '0;
                scan_row_next  = '0;
                scan_addr_next = '0;
                cur_col_next   = '0;
                cur_row_next   = '0;
                cur_known_next = 1'b0;
                st_attr_next   = '0;
                st_color_next  = '0;
                st_known_next  = 1'b0;
                wipe_next      = '0;
                state_next     = ST_WIPE;
            end
        end

        // Output register
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (emit && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            active_reg    <= 1'b0;
            shown_w_reg   <= '0;
            shown_h_reg   <= '0;
            area_reg      <= '0;
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            scan_addr_reg <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_known_reg <= 1'b0;
            st_attr_reg   <= '0;
            st_color_reg  <= '0;
            st_known_reg  <= 1'b0;
            sgr_pend_reg  <= 1'b0;
            seq_sel_reg   <= SEQ_CLS;
            idx_reg       <= '0;
            aphase_reg    <= 1'b0;
            sweep_reg     <= '0;
            wipe_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            active_reg    <= active_next;
            shown_w_reg   <= shown_w_next;
            shown_h_reg   <= shown_h_next;
            area_reg      <= area_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            scan_addr_reg <= scan_addr_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_known_reg <= cur_known_next;
            st_attr_reg   <= st_attr_next;
            st_color_reg  <= st_color_next;
            st_known_reg  <= st_known_next;
            sgr_pend_reg  <= sgr_pend_next;
            seq_sel_reg   <= seq_sel_next;
            idx_reg       <= idx_next;
            aphase_reg    <= aphase_next;
            sweep_reg     <= sweep_next;
            wipe_reg      <= wipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture cell payload and output byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= char_code;
            attr_reg  <= cell_attr;
            color_reg <= cell_color;
        end
        if (emit && out_free)
        begin
            out_byte_reg <= emit_byte;
            last_reg     <= emit_last;
        end
    end

    // Shown-cell memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

    `ASSERT_PROP(a_idle_pending_last, in_ready && out_valid_reg |-> last_reg,
        "byte pending while idle is not the last of its transaction")
    `ASSERT_PROP(a_sweep_in_range, state_reg == ST_SWP_WR |-> sweep_reg < area_reg,
        "size-change sweep beyond frame area")
    `ASSERT_PROP(a_dec_done_waited, dec_rsp.done |-> state_reg == ST_DEC_WAIT,
        "decimal result arrived while sequencer not waiting")
    `ASSERT_PROP(a_inactive_no_work, accept && !active_reg && !cfg_valid |=> in_ready,
        "item taken while inactive started work")

endmodule

FILE: dv/tcd_stream_checker.sv
// Checker of the terminal cell diff encoder: predicts the byte stream and compares it.
`timescale 1ns / 1ps
module tcd_stream_checker import tcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] frame_width,
    input  logic [6:0] frame_height,
    input  logic [7:0] char_code,
    input  logic [3:0] cell_attr,
    input  logic [3:0] cell_color,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       last_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         fail_count,
    output int         pending,
    output int         bytes_seen
);

    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 64;
    localparam logic [7:0] SGR_DIGIT [4] = '{8'h31, 8'h32, 8'h34, 8'h37};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    stream_byte_t expected_bytes [$];
    stream_byte_t item_bytes [$];

    logic [15:0] grid [GRID_COLS*GRID_ROWS];
    int  grid_w, grid_h, scan_c, scan_r, cur_c, cur_r;
    bit  cur_valid, style_valid, session_open;
    logic [3:0] style_attr, style_color;

    function automatic void emit(input logic [7:0] b);
        stream_byte_t e;
        e.data = b;
        e.last = 1'b0;
        item_bytes.push_back(e);
    endfunction

    function automatic void emit_dec(input int v);
        if (v >= 100)
            emit(CH_ZERO + 8'(v / 100));
        if (v >= 10)
            emit(CH_ZERO + 8'((v / 10) % 10));
        emit(CH_ZERO + 8'(v % 10));
    endfunction

    function automatic void wipe_screen();
        foreach (grid[i])
            grid[i] = '0;
        grid_w = 0; grid_h = 0; scan_c = 0; scan_r = 0; cur_c = 0; cur_r = 0;
        cur_valid = 0; style_valid = 0; style_attr = '0; style_color = '0;
    endfunction

    // Work out the bytes one accepted transaction causes and queue them
    function automatic void encode_item(input logic [1:0] kind, input logic [7:0] fw,
                                        input logic [6:0] fh, input logic [7:0] ch,
                                        input logic [3:0] attr, input logic [3:0] color);
        int w, h, idx;
        logic [15:0] now;
        stream_byte_t e;
        item_bytes.delete();
        if (!session_open)
            return;
        if (kind == REQ_START) begin
            w = (fw > GRID_COLS) ? GRID_COLS : fw;
            h = (fh > GRID_ROWS) ? GRID_ROWS : fh;
            if (w != grid_w || h != grid_h) begin
                emit(CH_ESC); emit(CH_LB); emit(CH_TWO); emit(CH_J);
                grid_w = w;
                grid_h = h;
                for (int i = 0; i < w * h; i++)
                    grid[i][7:0] = '0;
            end
            scan_c = 0;
            scan_r = 0;
            cur_valid = 0;
            style_valid = 0;
        end else if (kind == REQ_CELL) begin
            if (grid_w != 0 && scan_r < grid_h) begin
                idx = scan_r * grid_w + scan_c;
                now = {color, attr, ch};
                if (now != grid[idx]) begin
                    // Move the cursor unless it already sits on this cell
                    if (!(cur_valid && cur_r == scan_r && cur_c == scan_c)) begin
                        emit(CH_ESC); emit(CH_LB);
                        emit_dec(scan_r + 1); emit(CH_SEMI);
                        emit_dec(scan_c + 1); emit(CH_H);
                        cur_r = scan_r;
                        cur_c = scan_c;
                        cur_valid = 1;
                    end
                    // Resend the style only when it differs
                    if (!(style_valid && attr == style_attr && color == style_color)) begin
                        emit(CH_ESC); emit(CH_LB); emit(CH_ZERO);
                        for (int i = 0; i < 4; i++)
                            if (attr[i]) begin
                                emit(CH_SEMI);
                                emit(SGR_DIGIT[i]);
                            end
                        if (color != 0) begin
                            emit(CH_SEMI);
                            emit_dec(30 + color - 1);
                        end
                        emit(CH_M);
                        style_attr = attr;
                        style_color = color;
                        style_valid = 1;
                    end
                    emit((ch >= CH_SPACE && ch <= CH_TILDE) ? ch : CH_SPACE);
                    cur_c++;
                    grid[idx] = now;
                end
                scan_c++;
                if (scan_c >= grid_w) begin
                    scan_c = 0;
                    scan_r++;
                end
            end
        end else if (kind == REQ_END) begin
            emit(CH_ESC); emit(CH_LB); emit(CH_ZERO); emit(CH_M);
            scan_c = 0;
            scan_r = grid_h;
        end
        if (item_bytes.size() > 0) begin
            item_bytes[item_bytes.size()-1].last = 1'b1;
            foreach (item_bytes[i]) begin
                e = item_bytes[i];
                expected_bytes.push_back(e);
            end
        end
    endfunction

    // Track configuration, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        stream_byte_t exp_b;
        if (!rst_n) begin
            wipe_screen();
            session_open = 0;
            expected_bytes.delete();
            fail_count <= 0;
            bytes_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_data && !session_open)
                    wipe_screen();
                session_open = cfg_data;
            end
            if (in_valid && in_ready)
                encode_item(req_type, frame_width, frame_height, char_code,
                            cell_attr, cell_color);
            if (out_valid && out_ready) begin
                bytes_seen <= bytes_seen + 1;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected out_byte %02h last_byte %0b", out_byte, last_byte);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (out_byte !== exp_b.data) begin
                        $error("out_byte expected %02h actual %02h", exp_b.data, out_byte);
                        fail_count <= fail_count + 1;
                    end else if (last_byte !== exp_b.last) begin
                        $error("last_byte expected %0b actual %0b", exp_b.last, last_byte);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= expected_bytes.size();
    end

endmodule

FILE: dv/terminal_cell_diff_encoder_unit_test.sv
// Testbench top of the terminal cell diff encoder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module terminal_cell_diff_encoder_unit_test;
    import tcd_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int STALL_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 34000;
    localparam int PHASE_ITEMS  = 160;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [1:0] req_type = '0;
    logic [7:0] frame_width = '0;
    logic [6:0] frame_height = '0;
    logic [7:0] char_code = '0;
    logic [3:0] cell_attr = '0;
    logic [3:0] cell_color = '0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic       cfg_data = 0;

    int fail_count, pending, bytes_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int frames_sent = 0;
    int stall_cycles = 0;
    int last_w = 1, last_h = 1;

    always #1 clk = ~clk;

    terminal_cell_diff_encoder_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .frame_width(frame_width), .frame_height(frame_height),
        .char_code(char_code), .cell_attr(cell_attr), .cell_color(cell_color),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .last_byte(last_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tcd_stream_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .frame_width(frame_width), .frame_height(frame_height),
        .char_code(char_code), .cell_attr(cell_attr), .cell_color(cell_color),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .last_byte(last_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .bytes_seen(bytes_seen)
    );

    // Stall the receiver at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one input transaction and hold it until accepted
    task automatic send_item(input logic [1:0] kind, input logic [7:0] fw,
                             input logic [6:0] fh, input logic [7:0] ch,
                             input logic [3:0] attr, input logic [3:0] color);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        frame_width  <= fw;
        frame_height <= fh;
        char_code    <= ch;
        cell_attr    <= attr;
        cell_color   <= color;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_cell(input logic [7:0] ch, input logic [3:0] attr,
                             input logic [3:0] color);
        send_item(REQ_CELL, 8'($urandom), 7'($urandom), ch, attr, color);
    endtask

    task automatic send_start(input logic [7:0] fw, input logic [6:0] fh);
        send_item(REQ_START, fw, fh, 8'($urandom), 4'($urandom), 4'($urandom));
        frames_sent++;
    endtask

    task automatic send_end();
        send_item(REQ_END, 8'($urandom), 7'($urandom), 8'($urandom), 4'($urandom),
                  4'($urandom));
    endtask

    // Hold until every expected byte is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_session(input logic open);
        cfg_valid <= 1'b1;
        cfg_data  <= open;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One frame with random content; some frames are broken on purpose
    task automatic random_frame();
        int sel, w, h, cells;
        logic [7:0] ch;
        sel = $urandom_range(9);
        if (sel == 0) begin
            w = $urandom_range(100, 128);
            h = 1;
        end else if (sel == 1) begin
            w = 1;
            h = $urandom_range(10, 20);
        end else if (sel < 6) begin
            w = last_w;
            h = last_h;
        end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
        end
        last_w = w;
        last_h = h;
        send_start(8'(w), 7'(h));
        cells = w * h;
        if ($urandom_range(9) == 0)
            cells = $urandom_range(0, cells + 3);
        for (int i = 0; i < cells; i++) begin
            case ($urandom_range(3))
                0:       ch = "A";
                1:       ch = "B";
                2:       ch = 8'($urandom_range(32, 126));
                default: ch = 8'($urandom);
            endcase
            if ($urandom_range(19) == 0)
                send_item(REQ_NONE, 8'($urandom), 7'($urandom), ch, 4'($urandom),
                          4'($urandom));
            send_cell(ch, ($urandom_range(3) == 0) ? 4'($urandom) : 4'd0,
                      ($urandom_range(3) == 0) ? 4'($urandom) : 4'd1);
        end
        if ($urandom_range(14) != 0)
            send_end();
    endtask

    task automatic random_phase();
        int stop_at;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
            random_frame();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 20;
        recv_idle_pct = 86;

        // Open the session and walk the corner cases
        write_session(1'b1);
        send_cell("X", 4'd0, 4'd0);
        send_start(8'd255, 7'd127);
        send_cell(8'h00, 4'd0, 4'd0);
        send_cell(8'hFF, 4'hF, 4'hF);
        send_cell(8'h7E, 4'hF, 4'hF);
        send_cell(8'h1F, 4'd1, 4'd8);
        send_cell(8'h7F, 4'd2, 4'd9);
        send_cell("Z", 4'd4, 4'd0);
        send_cell("Y", 4'd8, 4'd1);
        send_item(REQ_NONE, 8'hFF, 7'h7F, 8'hFF, 4'hF, 4'hF);
        send_end();
        send_cell("Q", 4'd0, 4'd1);
        send_start(8'd200, 7'd100);
        send_cell(8'h00, 4'd0, 4'd0);
        send_end();
        send_start(8'd0, 7'd5);
        send_cell("a", 4'd0, 4'd0);
        send_end();
        send_start(8'd2, 7'd1);
        send_cell("k", 4'd3, 4'd2);
        send_cell("k", 4'd3, 4'd2);
        send_cell("m", 4'd0, 4'd0);
        send_end();
        random_phase();
        drain();

        // Closed session: everything is dropped
        write_session(1'b0);
        send_start(8'd3, 7'd2);
        send_cell("c", 4'd1, 4'd1);
        send_end();
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 20;
        write_session(1'b1);
        random_phase();
        drain();

        // Rewrite an open session: no clearing expected
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_session(1'b1);
        random_phase();
        drain();

        $display("covered %0d input items in %0d frames, %0d bytes checked",
                 items_sent, frames_sent, bytes_seen);
        $display("session closed and reopened, size changes, saturated and empty frames");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
